### rtl/crl_pkg.sv
// package for the client rate limiter
// types, constants and state codes; no dependencies
package crl_pkg;
   localparam int TableEntries = 16;
   localparam int IdxBits = $clog2(TableEntries);
   localparam int CntBits = $clog2(TableEntries + 1);

   localparam logic [1:0] ModeRequest = 2'd0;
   localparam logic [1:0] ModeTick = 2'd1;
   localparam logic [1:0] ModeSweep = 2'd2;

   localparam logic [1:0] CsrRequestLimit = 2'd0;
   localparam logic [1:0] CsrWindowTicks = 2'd1;
   localparam logic [1:0] CsrClientLimit = 2'd2;

   typedef struct packed {
      logic [1:0] mode;
      logic [31:0] client_key;
   } req_type;

   typedef struct packed {
      logic allowed;
      logic new_entry;
      logic evicted;
      logic [15:0] window_count;
      logic [4:0] removed;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_SCAN, ST_SWEEP, ST_VICTIM, ST_FREE, ST_FINISH, ST_RESPOND
   } state_type;
endpackage

### rtl/client_rate_limiter_lru_top.sv
// client rate limiter top level: fixed window limiter over a 16 entry lru table, uses crl_pkg
// synchronous reset empties the table, zeroes time and restores register defaults;
// tick and unused mode respond directly, a sweep walks the whole table, a hit scans
// up to the matching entry, a miss scans and then walks for a free slot, after a walk
// for the lru victim when the table is at the client limit; req_ready is high only while
// idle with no result held, so a new item is accepted only after the previous result is delivered
module client_rate_limiter_lru_top
   import crl_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [30:0] csr_data
);
   // configuration
   logic [15:0] limit_ff;
   logic [30:0] window_ff;
   logic [4:0]  clients_ff;

   // table: recency rank per entry, 0 = most recent; the ranks of valid entries
   // always form 0..n-1, so a removal closes its gap
   logic [31:0] key_ff [TableEntries];
   logic [15:0] count_ff [TableEntries];
   logic [31:0] start_ff [TableEntries];
   logic [IdxBits-1:0] rank_ff [TableEntries];
   logic [TableEntries-1:0] valid_ff;

   logic [31:0] time_ff;
   logic [CntBits-1:0] occ_ff;

   state_type state_ff, state_in;
   req_type item_ff;
   logic [IdxBits:0] ptr_ff;           // walk pointer, last entry = done
   logic hit_ff;
   logic [IdxBits-1:0] sel_ff;         // hit, victim or free slot
   logic have_ff;
   logic [CntBits-1:0] removed_ff;
   logic evict_ff;
   rsp_type out_ff;
   logic out_valid_ff;

   logic [IdxBits-1:0] ptr;
   logic walk_done;
   logic [31:0] elapsed;
   logic expired;
   logic [CntBits-1:0] lim;

   assign ptr = ptr_ff[IdxBits-1:0];
   assign walk_done = ptr_ff == (IdxBits+1)'(TableEntries - 1);
   // sweep unit: one modular subtract and compare per cycle at the pointer
   assign elapsed = time_ff - start_ff[ptr];
   assign expired = elapsed > {1'b0, window_ff};

   always_comb begin
      if (clients_ff == 5'd0) lim = CntBits'(1);
      else if (32'(clients_ff) > TableEntries) lim = CntBits'(TableEntries);
      else lim = CntBits'(clients_ff);
   end

   assign req_ready = (state_ff == ST_IDLE) && !out_valid_ff;
   assign rsp_valid = out_valid_ff;
   assign rsp_data = out_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_ready) begin
               unique case (req_data.mode)
                  ModeRequest: state_in = ST_SCAN;
                  ModeSweep: state_in = ST_SWEEP;
                  default: state_in = ST_RESPOND;
               endcase
            end
         end
         ST_SCAN: begin
            if (walk_done || (valid_ff[ptr] && key_ff[ptr] == item_ff.client_key))
               state_in = ST_FINISH;
         end
         ST_SWEEP: if (walk_done) state_in = ST_RESPOND;
         ST_VICTIM: if (walk_done) state_in = ST_FREE;
         ST_FREE: if (walk_done) state_in = ST_FINISH;
         ST_FINISH: begin
            if (!hit_ff && !evict_ff && occ_ff >= lim && !have_ff)
               state_in = ST_VICTIM;
            else if (!hit_ff && !have_ff)
               state_in = ST_FREE;
            else
               state_in = ST_RESPOND;
         end
         ST_RESPOND: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end

   // datapath sequencing
   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= 16'd10;
         window_ff <= 31'd1000;
         clients_ff <= 5'd16;
         valid_ff <= '0;
         time_ff <= '0;
         occ_ff <= '0;
         out_valid_ff <= 1'b0;
         ptr_ff <= '0;
         hit_ff <= 1'b0;
         have_ff <= 1'b0;
         evict_ff <= 1'b0;
         removed_ff <= '0;
      end else begin
         if (csr_write) begin
            unique case (csr_index)
               CsrRequestLimit: limit_ff <= csr_data[15:0];
               CsrWindowTicks: window_ff <= csr_data;
               CsrClientLimit: clients_ff <= csr_data[4:0];
               default: ;
            endcase
         end
         if (out_valid_ff && rsp_ready) out_valid_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (req_valid && req_ready) begin
                  item_ff <= req_data;
                  ptr_ff <= '0;
                  hit_ff <= 1'b0;
                  have_ff <= 1'b0;
                  evict_ff <= 1'b0;
                  removed_ff <= '0;
                  out_ff <= '0;
                  if (req_data.mode == ModeTick) time_ff <= time_ff + 32'd1;
               end
            end
            ST_SCAN: begin
               if (valid_ff[ptr] && key_ff[ptr] == item_ff.client_key) begin
                  hit_ff <= 1'b1;
                  sel_ff <= ptr;
               end
               ptr_ff <= ptr_ff + 1'b1;
            end
            ST_SWEEP: begin
               if (valid_ff[ptr] && expired) begin
                  valid_ff[ptr] <= 1'b0;
                  removed_ff <= removed_ff + 1'b1;
                  occ_ff <= occ_ff - 1'b1;
                  // entries older than the removed one move up by one
                  for (int i = 0; i < TableEntries; i++)
                     if (valid_ff[i] && rank_ff[i] > rank_ff[ptr])
                        rank_ff[i] <= rank_ff[i] - 1'b1;
               end
               ptr_ff <= ptr_ff + 1'b1;
            end
            ST_VICTIM: begin
               // oldest valid entry; ages are distinct among valid entries
               if (valid_ff[ptr] && (!have_ff || rank_ff[ptr] > rank_ff[sel_ff])) begin
                  have_ff <= 1'b1;
                  sel_ff <= ptr;
               end
               ptr_ff <= ptr_ff + 1'b1;
               if (walk_done) begin
                  ptr_ff <= '0;
                  evict_ff <= 1'b1;
                  if (have_ff || valid_ff[ptr]) begin
                     valid_ff[(valid_ff[ptr] && (!have_ff ||
                        rank_ff[ptr] > rank_ff[sel_ff])) ? ptr : sel_ff] <= 1'b0;
                     occ_ff <= occ_ff - 1'b1;
                     out_ff.evicted <= 1'b1;
                  end
                  have_ff <= 1'b0;
               end
            end
            ST_FREE: begin
               // first free slot; ages of older entries bumped on insert
               if (!valid_ff[ptr] && !have_ff) begin
                  have_ff <= 1'b1;
                  sel_ff <= ptr;
               end
               ptr_ff <= ptr_ff + 1'b1;
            end
            ST_FINISH: begin
               ptr_ff <= '0;
               if (hit_ff) begin
                  for (int i = 0; i < TableEntries; i++)
                     if (valid_ff[i] && rank_ff[i] < rank_ff[sel_ff])
                        rank_ff[i] <= rank_ff[i] + 1'b1;
                  rank_ff[sel_ff] <= '0;
                  begin
                     logic [15:0] c;
                     logic [31:0] el;
                     el = time_ff - start_ff[sel_ff];
                     c = (el > {1'b0, window_ff}) ? 16'd0 : count_ff[sel_ff];
                     if (el > {1'b0, window_ff}) start_ff[sel_ff] <= time_ff;
                     if (c < limit_ff) begin
                        c = c + 16'd1;
                        out_ff.allowed <= 1'b1;
                     end
                     count_ff[sel_ff] <= c;
                     out_ff.window_count <= c;
                  end
               end else if (have_ff) begin
                  for (int i = 0; i < TableEntries; i++)
                     if (valid_ff[i] && rank_ff[i] != '1)
                        rank_ff[i] <= rank_ff[i] + 1'b1;
                  valid_ff[sel_ff] <= 1'b1;
                  key_ff[sel_ff] <= item_ff.client_key;
                  count_ff[sel_ff] <= 16'd1;
                  start_ff[sel_ff] <= time_ff;
                  rank_ff[sel_ff] <= '0;
                  occ_ff <= occ_ff + 1'b1;
                  out_ff.allowed <= 1'b1;
                  out_ff.new_entry <= 1'b1;
                  out_ff.window_count <= 16'd1;
               end
            end
            ST_RESPOND: begin
               if (item_ff.mode == ModeSweep) out_ff.removed <= 5'(removed_ff);
               out_valid_ff <= 1'b1;
            end
            default: ;
         endcase
      end
   end
endmodule
